@@ rtl/b2da_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants of the binary to decimal ASCII block
// Widths, digit count, state codes and control structs.
// ----------------------------------------------------------------------------
package b2da_pkg;

	localparam int VALUE_BITS = 64;
	localparam int IN_W       = 64;
	localparam int CHAR_W     = 6;
	localparam int DIGIT_W    = 4;

	// upper bound on decimal digits of a VALUE_BITS-bit number
	localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W  = DIGITS * DIGIT_W;
	localparam int CNT_W  = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;
	localparam int REM_W  = $clog2(DIGITS + 1);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} b2da_state_t;

	typedef struct packed {
		logic load;
		logic shift_digit;
	} b2da_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} b2da_stat_t;

endpackage
`default_nettype wire

@@ rtl/b2da_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_if: valid/ready channels of the binary to decimal ASCII block
// One channel carries the binary number, the other one digit per item.
// ----------------------------------------------------------------------------
interface b2da_num_if;
	import b2da_pkg::*;

	logic            valid;
	logic            ready;
	logic [IN_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface b2da_dig_if;
	import b2da_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last_digit;

	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface
`default_nettype wire

@@ rtl/b2da_dabble.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_dabble: bit-serial double dabble converter
// Shifts the binary operand in one bit per cycle with add-3 correction,
// then shifts the BCD digits out one digit per command.
// ----------------------------------------------------------------------------
module b2da_dabble (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire b2da_pkg::b2da_ctl_t      ctl,
	input  wire logic [b2da_pkg::IN_W-1:0] value,
	output b2da_pkg::b2da_stat_t          status,
	output logic [b2da_pkg::DIGIT_W-1:0]  top_digit
);
	import b2da_pkg::*;

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      adj;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.load) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bin_q <= value[VALUE_BITS-1:0];
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
		end else if (ctl.shift_digit) begin
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
	end

	assign status      = '{busy: busy_q, done: done_q};
	assign top_digit   = bcd_q[BCD_W-1 -: DIGIT_W];

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !busy_q)
		else $error("load while converting");

	a_load_starts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> busy_q)
		else $error("load did not start a pass");

	a_done_ends_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("done without a finished pass");

endmodule
`default_nettype wire

@@ rtl/binary_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ASCII digit stream
// Each accepted number yields its decimal digits as ASCII items, most
// significant first, no leading zeros, last digit flagged; zero gives '0'.
// ----------------------------------------------------------------------------
// One number at a time. After acceptance the double dabble pass shifts in
// one operand bit per cycle and then hands over to the controller, which
// drops leading zeros at one digit per cycle, moves to output and offers
// each remaining digit until it is taken, so an output stall holds it. A
// new number is taken once the last digit is taken.
module binary_to_decimal_ascii (
	input  wire logic   clk,
	input  wire logic   arst_n,
	b2da_num_if.sink    number,
	b2da_dig_if.source  digits
);
	import b2da_pkg::*;

	b2da_state_t         state_q, state_d;
	logic [REM_W-1:0]    rem_q, rem_d;
	b2da_ctl_t           ctl;
	b2da_stat_t          status;
	logic [DIGIT_W-1:0]  top_digit;

	b2da_dabble u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.value     (number.value),
		.status    (status),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		rem_d           = rem_q;
		ctl.load        = 1'b0;
		ctl.shift_digit = 1'b0;
		number.ready    = 1'b0;
		digits.valid    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				number.ready = 1'b1;
				if (number.valid) begin
					ctl.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				if (status.done) begin
					rem_d   = REM_W'(DIGITS);
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (top_digit == '0 && rem_q != REM_W'(1)) begin
					ctl.shift_digit = 1'b1;
					rem_d           = rem_q - 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				digits.valid = 1'b1;
				if (digits.ready) begin
					if (rem_q == REM_W'(1)) begin
						state_d = ST_IDLE;
					end else begin
						ctl.shift_digit = 1'b1;
						rem_d           = rem_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign digits.digit_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
	assign digits.last_digit = (rem_q == REM_W'(1));

	a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		digits.valid |-> top_digit <= DIGIT_W'(9))
		else $error("non-decimal digit offered");

	a_conv_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> state_q == ST_CONV)
		else $error("converter busy outside conversion");

	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && $past(state_q) == ST_SKIP)
		|-> (top_digit != '0 || rem_q == REM_W'(1)))
		else $error("leading zero emitted");

endmodule
`default_nettype wire
